// File: hdl/krs_pkg.sv
// shared constants and types for the keyed register store
package krs_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = 40;
    localparam int COUNT_OUT_W = 7;

    localparam logic [7:0] CMD_READ = 8'h52;
    localparam logic [7:0] CMD_WRITE = 8'h57;
    localparam logic [15:0] LEN_MIN = 16'd11;
    localparam logic [15:0] LEN_MAX = 16'd13;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic [15:0] dev_id;
        logic [7:0]  reg_id;
        logic [15:0] value;
    } t_entry;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [15:0]      value;
    } t_search;

endpackage

// File: hdl/krs_req_if.sv
// request channel: parsed command with key, value and length
interface krs_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command;
    logic [15:0] device_id;
    logic [7:0]  register_id;
    logic [15:0] write_value;
    logic [15:0] message_length;

    modport source (
        output valid, command, device_id, register_id, write_value, message_length,
        input  ready
    );
    modport sink (
        input  valid, command, device_id, register_id, write_value, message_length,
        output ready
    );
endinterface

// File: hdl/krs_rsp_if.sv
// response channel: status, echoed key, value and entry count
interface krs_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] out_device;
    logic [7:0]  out_register;
    logic [15:0] out_value;
    logic [6:0]  entry_count;

    modport source (
        output valid, status, out_device, out_register, out_value, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_device, out_register, out_value, entry_count,
        output ready
    );
endinterface

// File: hdl/keyed_register_store_top.sv
// keyed register store: request control, valid bits, entry ram and response register
// a well-formed request walks the entry ram one slot per cycle until the first match or the last slot,
// then passes through the update state before the response register loads
// a request with a bad length or command skips the search and goes straight to the reply state
// one request at a time: ready rises the cycle after the response register loads,
// and that load waits while an earlier response is still held
// reset clears the valid bits and the entry count; the ram itself is not cleared
module keyed_register_store_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    krs_req_if.sink    i_req,
    krs_rsp_if.source  o_rsp
);
    import krs_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [7:0]  r_cmd;
    logic [15:0] r_dev;
    logic [7:0]  r_reg;
    logic [15:0] r_wval;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]         r_count;

    logic        r_res_err;
    logic [15:0] r_res_value;

    logic        r_o_valid;
    logic        r_o_status;
    logic [15:0] r_o_device;
    logic [7:0]  r_o_register;
    logic [15:0] r_o_value;
    logic [6:0]  r_o_count;

    logic             req_xfer;
    logic             req_ok;
    logic             search_start;
    logic             is_write;
    logic             upd_err;
    logic             ram_we;
    logic             new_entry;
    logic [IDX_W-1:0] ram_waddr;
    logic             out_load;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    t_entry           wr_data;
    t_search          res;

    assign req_ok = (i_req.message_length inside {[LEN_MIN:LEN_MAX]})
                    && (i_req.command inside {CMD_READ, CMD_WRITE});
    assign is_write = (r_cmd == CMD_WRITE);
    assign upd_err = is_write ? (!res.hit && !res.free_found) : !res.hit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_state = req_ok ? S_SEARCH : S_REPLY;
                end
            end
            S_SEARCH: begin
                if (res.done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready  = 1'b0;
        search_start = 1'b0;
        ram_we       = 1'b0;
        out_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready  = 1'b1;
                search_start = i_req.valid && req_ok;
            end
            S_UPDATE: begin
                ram_we = is_write && !upd_err;
            end
            S_REPLY: begin
                out_load = !r_o_valid || o_rsp.ready;
            end
            default: begin
            end
        endcase
    end

    assign req_xfer  = i_req.valid && i_req.ready;
    assign new_entry = ram_we && !res.hit;
    assign ram_waddr = res.hit ? res.hit_idx : res.free_idx;

    always_comb begin
        wr_data.dev_id = r_dev;
        wr_data.reg_id = r_reg;
        wr_data.value  = r_wval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (new_entry) begin
                r_valid[res.free_idx] <= 1'b1;
                r_count               <= r_count + 1'b1;
            end
        end
    end

    // request capture and result
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_cmd     <= i_req.command;
            r_dev     <= i_req.device_id;
            r_reg     <= i_req.register_id;
            r_wval    <= i_req.write_value;
            r_res_err <= !req_ok;
        end
        if (r_state == S_UPDATE) begin
            r_res_err   <= upd_err;
            r_res_value <= is_write ? r_wval : res.value;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status   <= r_res_err;
            r_o_device   <= r_res_err ? 16'd0 : r_dev;
            r_o_register <= r_res_err ? 8'd0 : r_reg;
            r_o_value    <= r_res_err ? 16'd0 : r_res_value;
            r_o_count    <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.out_device   = r_o_device;
    assign o_rsp.out_register = r_o_register;
    assign o_rsp.out_value    = r_o_value;
    assign o_rsp.entry_count  = r_o_count;

    krs_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (search_start),
        .i_key_dev (r_dev),
        .i_key_reg (r_reg),
        .i_valid   (r_valid),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_res     (res)
    );

    krs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("entry count differs from valid bits");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        new_entry |-> !r_valid[res.free_idx])
        else $error("insert into an occupied slot");
`endif
endmodule

// File: hdl/krs_ram.sv
// generic simple dual-port ram with registered read
module krs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/krs_search.sv
// sequential key search over the entry ram, also finds the lowest free slot among the slots it scans
module krs_search (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [15:0]                            i_key_dev,
    input  logic [7:0]                             i_key_reg,
    input  logic [krs_pkg::TABLE_ENTRIES-1:0]      i_valid,
    input  krs_pkg::t_entry                        i_rd_data,
    output logic [krs_pkg::IDX_W-1:0]              o_rd_addr,
    output krs_pkg::t_search                       o_res
);
    import krs_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic             r_busy;
    logic             r_issue;
    logic [IDX_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_done;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic [15:0]      r_value;

    logic cur_valid;
    logic cur_match;

    assign cur_valid = i_valid[r_cmp_idx];
    assign cur_match = cur_valid && (i_rd_data.dev_id == i_key_dev)
                       && (i_rd_data.reg_id == i_key_reg);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_issue   <= 1'b1;
                r_cmp_vld <= 1'b0;
            end else if (r_busy) begin
                r_cmp_vld <= r_issue;
                if (r_issue && (r_idx == LAST_IDX)) begin
                    r_issue <= 1'b0;
                end
                // stop at the first match or after the last slot
                if (r_cmp_vld && (cur_match || (r_cmp_idx == LAST_IDX))) begin
                    r_busy    <= 1'b0;
                    r_issue   <= 1'b0;
                    r_cmp_vld <= 1'b0;
                    r_done    <= 1'b1;
                end
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_busy) begin
            r_cmp_idx <= r_idx;
            if (r_issue && (r_idx != LAST_IDX)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_cmp_vld) begin
                if (!cur_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                if (cur_match) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_value   <= i_rd_data.value;
                end
            end
        end
    end

    assign o_rd_addr = r_idx;

    always_comb begin
        o_res.done       = r_done;
        o_res.hit        = r_hit;
        o_res.hit_idx    = r_hit_idx;
        o_res.free_found = r_free_found;
        o_res.free_idx   = r_free_idx;
        o_res.value      = r_value;
    end

`ifndef SYNTHESIS
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> r_busy)
        else $error("compare stage active outside a search");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("search started while busy");
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_hit) |-> i_valid[r_hit_idx])
        else $error("search hit on an invalid slot");
    a_free_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_free_found) |-> !i_valid[r_free_idx])
        else $error("free slot reported as valid");
`endif
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for keyed_register_store_top: directed and random requests checked against a table model
module testbench;
    import krs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_LINES = 40;
    localparam int POOL_MAX = 100;
    localparam logic [7:0] CMD_LOWER_READ = 8'h72;
    localparam logic [7:0] CMD_LOWER_WRITE = 8'h77;
    localparam logic [7:0] CMD_NEIGHBOR = 8'h53;

    typedef struct {
        logic        status;
        logic [15:0] dev_id;
        logic [7:0]  reg_id;
        logic [15:0] value;
        logic [6:0]  count;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    krs_req_if req_ch ();
    krs_rsp_if rsp_ch ();

    keyed_register_store_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the table
    t_entry      shadow_entries [TABLE_ENTRIES];
    bit          shadow_used [TABLE_ENTRIES];
    int unsigned shadow_count;

    t_reply      pending_replies [$];
    int unsigned mismatch_count;
    int unsigned reply_count;
    int unsigned cycle_count;
    int          burst_left;

    logic [15:0] pool_dev [POOL_MAX];
    logic [7:0]  pool_reg [POOL_MAX];

    logic [15:0] stall_pattern;
    int          pattern_left;

    function automatic t_reply table_lookup(input logic [7:0] cmd, input logic [15:0] dev,
                                            input logic [7:0] rid, input logic [15:0] val,
                                            input logic [15:0] len);
        t_reply r;
        int     hit;
        int     spot;
        r.status = 1'b1;
        r.dev_id = '0;
        r.reg_id = '0;
        r.value = '0;
        hit = -1;
        spot = -1;
        if (len >= LEN_MIN && len <= LEN_MAX && (cmd == CMD_READ || cmd == CMD_WRITE)) begin
            for (int i = 0; i < TABLE_ENTRIES && hit < 0; i++) begin
                if (shadow_used[i] && shadow_entries[i].dev_id == dev &&
                        shadow_entries[i].reg_id == rid)
                    hit = i;
            end
            if (cmd == CMD_READ) begin
                if (hit >= 0) begin
                    r.status = 1'b0;
                    r.dev_id = shadow_entries[hit].dev_id;
                    r.reg_id = shadow_entries[hit].reg_id;
                    r.value = shadow_entries[hit].value;
                end
            end else begin
                if (hit >= 0) begin
                    shadow_entries[hit].value = val;
                    r.status = 1'b0;
                end else begin
                    for (int i = 0; i < TABLE_ENTRIES && spot < 0; i++) begin
                        if (!shadow_used[i])
                            spot = i;
                    end
                    // a new key with no free slot is refused
                    if (spot >= 0) begin
                        shadow_entries[spot] = '{dev_id: dev, reg_id: rid, value: val};
                        shadow_used[spot] = 1'b1;
                        shadow_count++;
                        r.status = 1'b0;
                    end
                end
                if (!r.status) begin
                    r.dev_id = dev;
                    r.reg_id = rid;
                    r.value = val;
                end
            end
        end
        r.count = shadow_count[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < REPORT_LINES)
            $display("reply %0d: %s got %h want %h", reply_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [7:0] cmd, input logic [15:0] dev,
                                input logic [7:0] rid, input logic [15:0] val,
                                input logic [15:0] len);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.device_id <= dev;
        req_ch.register_id <= rid;
        req_ch.write_value <= val;
        req_ch.message_length <= len;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_replies.push_back(table_lookup(cmd, dev, rid, val, len));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_write_read;
        send_request(CMD_WRITE, 16'h1234, 8'h56, 16'hABCD, 16'(LEN_MIN + 1));
        send_request(CMD_READ, 16'h1234, 8'h56, 16'h0000, 16'(LEN_MIN + 1));
        send_request(CMD_READ, 16'h1234, 8'h57, 16'h0000, 16'(LEN_MIN + 1));
        send_request(CMD_WRITE, 16'h1234, 8'h56, 16'h0001, LEN_MIN);
        send_request(CMD_READ, 16'h1234, 8'h56, 16'hFFFF, LEN_MAX);
    endtask

    task automatic test_bad_length;
        send_request(CMD_WRITE, 16'h0042, 8'h11, 16'h5555, 16'(LEN_MIN - 1));
        send_request(CMD_WRITE, 16'h0042, 8'h11, 16'h5555, 16'(LEN_MAX + 1));
        send_request(CMD_READ, 16'h1234, 8'h56, 16'h0000, 16'h0000);
        send_request(CMD_WRITE, 16'h1234, 8'h56, 16'h7777, 16'hFFFF);
        send_request(CMD_READ, 16'h1234, 8'h56, 16'h0000, 16'h8000);
    endtask

    task automatic test_illegal_command;
        send_request(8'h00, 16'h1234, 8'h56, 16'h2222, 16'(LEN_MIN + 1));
        send_request(8'hFF, 16'h1234, 8'h56, 16'h2222, 16'(LEN_MIN + 1));
        send_request(CMD_LOWER_READ, 16'h1234, 8'h56, 16'h2222, LEN_MIN);
        send_request(CMD_LOWER_WRITE, 16'h1234, 8'h56, 16'h2222, LEN_MAX);
        send_request(CMD_NEIGHBOR, 16'h1234, 8'h56, 16'h2222, 16'(LEN_MIN + 1));
    endtask

    task automatic test_key_extremes;
        send_request(CMD_WRITE, 16'hFFFF, 8'hFF, 16'hFFFF, LEN_MAX);
        send_request(CMD_WRITE, 16'h0000, 8'h00, 16'h0000, LEN_MIN);
        send_request(CMD_READ, 16'hFFFF, 8'hFF, 16'h0000, LEN_MIN);
        send_request(CMD_READ, 16'h0000, 8'h00, 16'hFFFF, LEN_MAX);
        send_request(CMD_WRITE, 16'h0000, 8'hFF, 16'h8000, 16'(LEN_MIN + 1));
        send_request(CMD_READ, 16'hFFFF, 8'h00, 16'h0000, 16'(LEN_MIN + 1));
        send_request(CMD_READ, 16'h0000, 8'hFF, 16'h0000, 16'(LEN_MIN + 1));
    endtask

    // mostly well-formed traffic on a key pool, with a share of misses and malformed requests
    task automatic send_pool_traffic(input int count, input int pool_size, input int write_pct,
                                     input int read_pct);
        int          k;
        int          roll;
        logic [7:0]  cmd;
        logic [15:0] len;
        for (int n = 0; n < pool_size; n++) begin
            pool_dev[n] = 16'($urandom_range(0, 65535));
            pool_reg[n] = 8'($urandom_range(0, 255));
        end
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, pool_size - 1);
            roll = $urandom_range(0, 99);
            len = 16'($urandom_range(LEN_MIN, LEN_MAX));
            if (roll < write_pct) begin
                send_request(CMD_WRITE, pool_dev[k], pool_reg[k],
                             16'($urandom_range(0, 65535)), len);
            end else if (roll < write_pct + read_pct) begin
                send_request(CMD_READ, pool_dev[k], pool_reg[k],
                             16'($urandom_range(0, 65535)), len);
            end else if (roll < write_pct + read_pct + 6) begin
                send_request(CMD_READ, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), len);
            end else if (roll < write_pct + read_pct + 9) begin
                send_request(CMD_WRITE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), len);
            end else if (roll < write_pct + read_pct + 15) begin
                case ($urandom_range(0, 3))
                    0: len = 16'(LEN_MIN - 1);
                    1: len = 16'(LEN_MAX + 1);
                    default: begin
                        do len = 16'($urandom_range(0, 65535));
                        while (len >= LEN_MIN && len <= LEN_MAX);
                    end
                endcase
                case ($urandom_range(0, 2))
                    0: cmd = CMD_READ;
                    1: cmd = CMD_WRITE;
                    default: cmd = 8'($urandom_range(0, 255));
                endcase
                send_request(cmd, pool_dev[k], pool_reg[k], 16'($urandom_range(0, 65535)), len);
            end else begin
                do cmd = 8'($urandom_range(0, 255)); while (cmd == CMD_READ || cmd == CMD_WRITE);
                send_request(cmd, pool_dev[k], pool_reg[k], 16'($urandom_range(0, 65535)), len);
            end
        end
    endtask

    task automatic test_random_traffic;
        send_pool_traffic(350, 40, 40, 40);
    endtask

    // a wider pool runs the table full, then new keys are refused and present keys still update
    task automatic test_table_fill;
        send_pool_traffic(380, POOL_MAX, 55, 30);
    endtask

    // receiver stalls on a rotating pattern, reloaded now and then, sometimes all ready
    always @(posedge i_clk) begin
        if (pattern_left == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            pattern_left <= $urandom_range(16, 80);
        end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            pattern_left <= pattern_left - 1;
        end
        rsp_ch.ready <= stall_pattern[15];
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected transfer, status", 32'(rsp_ch.status), 0);
            end else begin
                want = pending_replies.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.out_device !== want.dev_id)
                    report_mismatch("out_device", 32'(rsp_ch.out_device), 32'(want.dev_id));
                if (rsp_ch.out_register !== want.reg_id)
                    report_mismatch("out_register", 32'(rsp_ch.out_register),
                                    32'(want.reg_id));
                if (rsp_ch.out_value !== want.value)
                    report_mismatch("out_value", 32'(rsp_ch.out_value), 32'(want.value));
                if (rsp_ch.entry_count !== want.count)
                    report_mismatch("entry_count", 32'(rsp_ch.entry_count), 32'(want.count));
            end
            reply_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = '0;
        req_ch.device_id = '0;
        req_ch.register_id = '0;
        req_ch.write_value = '0;
        req_ch.message_length = '0;
        rsp_ch.ready = 1'b0;
        stall_pattern = 16'hF0F3;
        pattern_left = 0;
        cycle_count = 0;
        mismatch_count = 0;
        reply_count = 0;
        burst_left = 0;
        shadow_count = 0;
        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_write_read();
        test_bad_length();
        test_illegal_command();
        test_key_extremes();
        test_random_traffic();
        test_table_fill();

        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
